// ===== hdl/brlr_pkg.sv =====
// Package for the byte ring buffer line reader.
// Holds the item and result structs, the controller state, command and status types.
// No dependencies.
`default_nettype none

package brlr_pkg;

  // Fixed field widths
  localparam int LEN_W  = 7;
  localparam int FREE_W = 11;

  localparam logic [7:0] NEWLINE = 8'h0A;

  // Item kind codes
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] max_len;
  } item_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              line_found;
    logic              accepted;
    logic              last;
    logic [FREE_W-1:0] free_space;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic write_item;
    logic flush_item;
    logic idle_result;
    logic scan_init;
    logic scan_miss;
    logic emit_init;
    logic walk;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_hit;
    logic scan_end;
    logic emit_last;
  } ctl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/brlr_ctrl.sv =====
// Controller state machine of the line reader: decodes transactions and sequences
// the scan and emit passes. Depends on brlr_pkg.
`default_nettype none

module brlr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          kind,
  input  wire brlr_pkg::ctl_stat_t stat,
  output brlr_pkg::ctl_cmd_t       cmd,
  output logic                     busy
);
  import brlr_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (kind_t'(kind) == KIND_READ)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_hit) begin
          state_next = ST_EMIT;
        end else if (stat.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_WRITE: cmd.write_item  = 1'b1;
            KIND_READ:  cmd.scan_init   = 1'b1;
            KIND_FLUSH: cmd.flush_item  = 1'b1;
            default:    cmd.idle_result = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.scan_hit) begin
          cmd.emit_init = 1'b1;
        end else if (stat.scan_end) begin
          cmd.scan_miss = 1'b1;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.walk = 1'b1;
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/brlr_dpath.sv =====
// Datapath of the line reader: byte store, ring pointers, fill count,
// scan/emit walker and the registered result. Depends on brlr_pkg.
`default_nettype none

module brlr_dpath #(
  parameter int DEPTH    = 1024,
  parameter int MAX_LINE = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire brlr_pkg::item_t     item,
  input  wire brlr_pkg::ctl_cmd_t  cmd,
  output brlr_pkg::ctl_stat_t      stat,
  output brlr_pkg::result_t        result,
  output logic                     result_valid
);
  import brlr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [LEN_W-1:0] MAX_C    = LEN_W'(MAX_LINE);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] fill;
  logic [PTR_W-1:0] scan_ptr;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] issued;
  logic [LEN_W-1:0] checked;
  logic             pend;

  logic             wr_en;
  logic             rd_en;
  logic [LEN_W-1:0] lim;
  logic [CMP_W-1:0] lim_w;
  logic [CMP_W-1:0] fill_w;
  logic [LEN_W-1:0] window_next;
  logic [LEN_W-1:0] checked_inc;
  logic [CNT_W-1:0] fill_line;
  logic             emit_out;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Window of a read-line transaction: min(max_len, MAX_LINE, fill)
  assign lim         = (item.max_len > MAX_C) ? MAX_C : item.max_len;
  assign lim_w       = CMP_W'(lim);
  assign fill_w      = CMP_W'(fill);
  assign window_next = (fill_w < lim_w) ? LEN_W'(fill_w) : lim;

  assign wr_en       = cmd.write_item && (fill != DEPTH_C);
  assign rd_en       = cmd.walk && (issued < limit);
  assign checked_inc = checked + 1'b1;
  assign fill_line   = fill - CNT_W'(limit);
  assign emit_out    = cmd.emit && pend;

  // Status to the controller
  assign stat.scan_hit  = pend && (rd_data == NEWLINE);
  assign stat.scan_end  = (checked == limit);
  assign stat.emit_last = pend && (checked_inc == limit);

  // Byte store: one write port at the tail, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= item.data_byte;
    end
    if (rd_en) begin
      rd_data <= mem[scan_ptr];
    end
  end

  // Ring pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (cmd.flush_item) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (wr_en) begin
      tail <= advance(tail);
      fill <= fill + 1'b1;
    end else if (emit_out && stat.emit_last) begin
      head <= scan_ptr;
      fill <= fill_line;
    end
  end

  // Walker: issue one read per cycle while the controller walks, check the byte in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr <= '0;
      limit    <= '0;
      issued   <= '0;
      checked  <= '0;
      pend     <= 1'b0;
    end else if (cmd.scan_init || cmd.emit_init) begin
      scan_ptr <= head;
      limit    <= cmd.scan_init ? window_next : checked_inc;
      issued   <= '0;
      checked  <= '0;
      pend     <= 1'b0;
    end else if (cmd.walk) begin
      if (rd_en) begin
        scan_ptr <= advance(scan_ptr);
        issued   <= issued + 1'b1;
      end
      if (pend) begin
        checked <= checked_inc;
      end
      pend <= rd_en;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.write_item || cmd.flush_item || cmd.idle_result ||
                      cmd.scan_miss || emit_out;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    result.read_byte  <= 8'h00;
    result.line_found <= 1'b0;
    result.accepted   <= 1'b0;
    result.last       <= 1'b1;
    result.free_space <= FREE_W'(DEPTH_C - fill);
    if (cmd.write_item) begin
      result.accepted   <= wr_en;
      result.free_space <= FREE_W'(DEPTH_C - fill - CNT_W'(wr_en));
    end else if (cmd.flush_item) begin
      result.free_space <= FREE_W'(DEPTH_C);
    end else if (emit_out) begin
      result.read_byte  <= rd_data;
      result.line_found <= 1'b1;
      result.last       <= stat.emit_last;
      result.free_space <= FREE_W'(DEPTH_C - fill_line);
    end
  end

`ifndef SYNTHESIS
  // Fill count never exceeds the store size
  assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_C)
    else $error("fill count above depth");

  // Checks trail issued reads by at most one
  assert property (@(posedge clk) disable iff (rst)
    (issued == checked) || (issued == checked_inc))
    else $error("walker issue/check skew");

  // Line bytes come out back to back until the last one
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid && result.line_found)
    else $error("line transaction broken up");

  // A line result never reports an accepted write
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.line_found |-> !result.accepted)
    else $error("line result flagged accepted");
`endif

endmodule

`default_nettype wire

// ===== hdl/byte_ring_buffer_line_reader.sv =====
// Byte ring buffer line reader: write and flush transactions finish in the accept cycle,
// busy stays low and their result strobes in the next cycle (one transaction per cycle).
// A read-line transaction walks the single memory read port twice for a line, a scan pass
// then an emit pass, keeping busy high and emitting one byte per cycle; a miss ends after the
// scan pass, which reads nothing when the window is empty.
// Synchronous reset empties the buffer; the byte store itself is not cleared.
`default_nettype none

module byte_ring_buffer_line_reader #(
  parameter int DEPTH    = 1024,
  parameter int MAX_LINE = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire brlr_pkg::item_t   item,
  output brlr_pkg::result_t      result,
  output logic                   result_valid
);
  import brlr_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  brlr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  brlr_dpath #(
    .DEPTH    (DEPTH),
    .MAX_LINE (MAX_LINE)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the byte ring buffer line reader.
// Depends on brlr_pkg for the item and result structs and the kind codes,
// and on the byte_ring_buffer_line_reader RTL.
`timescale 1ns / 1ps

module testbench;
  import brlr_pkg::*;

  localparam int DEPTH    = 1024;
  localparam int MAX_LINE = 64;
  localparam int RANDOM_ITEMS = 380;
  localparam int REPORT_LIMIT = 10;
  // Kind code the block does not define; it must still answer with one result
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  result_t result;
  logic    result_valid;

  // Shadow copy of the ring buffer
  logic [7:0]  ring_mem [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  int unsigned ring_fill = 0;

  result_t expected_results [$];
  int      mismatches = 0;
  bit      sender_idle_on = 1'b1;
  int      random_items = 0;

  stim_row_t directed_rows [23];

  byte_ring_buffer_line_reader #(
    .DEPTH    (DEPTH),
    .MAX_LINE (MAX_LINE)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid)
  );

  always #1 clk = ~clk;

  // Predict the results of one transaction and advance the shadow buffer
  function automatic void ring_step(input item_t it, ref result_t outs[$]);
    int unsigned window;
    int unsigned n;
    int unsigned p;
    int unsigned i;
    bit          found;
    result_t     r;
    outs.delete();
    r = '0;
    r.last = 1'b1;
    case (it.kind)
      KIND_WRITE: begin
        if (ring_fill < DEPTH) begin
          ring_mem[ring_tail] = it.data_byte;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_fill++;
          r.accepted = 1'b1;
        end
      end
      KIND_READ: begin
        window = it.max_len;
        if (window > MAX_LINE) window = MAX_LINE;
        if (window > ring_fill) window = ring_fill;
        found = 1'b0;
        n = 0;
        p = ring_head;
        // Scan the window for the first newline
        while (n < window && !found) begin
          if (ring_mem[p] == NEWLINE) found = 1'b1;
          p = (p + 1) % DEPTH;
          n++;
        end
        if (found) begin
          ring_fill -= n;
          for (i = 0; i < n; i++) begin
            r = '0;
            r.read_byte  = ring_mem[(ring_head + i) % DEPTH];
            r.line_found = 1'b1;
            r.last       = (i == n - 1);
            r.free_space = FREE_W'(DEPTH - ring_fill);
            outs.push_back(r);
          end
          ring_head = p;
          return;
        end
      end
      KIND_FLUSH: begin
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
      end
      default: ;
    endcase
    r.free_space = FREE_W'(DEPTH - ring_fill);
    outs.push_back(r);
  endfunction

  // Single-result answer of a write, flush, miss or unused kind
  function automatic result_t single_res(input bit acc, input int free);
    result_t r;
    r = '0;
    r.accepted   = acc;
    r.last       = 1'b1;
    r.free_space = FREE_W'(free);
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == NEWLINE);
    return b;
  endfunction

  // Drive one transaction at the falling edge and hold it until accepted
  task automatic send_item(input item_t it, input bit typed = 1'b0,
                           input result_t typed_res = '0);
    result_t outs [$];
    int      gap;
    gap = sender_idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    ring_step(it, outs);
    if (typed) expected_results.push_back(typed_res);
    else foreach (outs[k]) expected_results.push_back(outs[k]);
  endtask

  task automatic issue(input logic [1:0] kind, input logic [7:0] data,
                       input logic [LEN_W-1:0] len);
    item_t it;
    it.kind      = kind;
    it.data_byte = data;
    it.max_len   = len;
    send_item(it);
  endtask

  // Write a line of len bytes; an unterminated one ends in a text byte
  task automatic push_line(input int len, input bit terminated);
    for (int i = 1; i < len; i++) issue(KIND_WRITE, text_byte(), 7'($urandom));
    issue(KIND_WRITE, terminated ? NEWLINE : text_byte(), 7'($urandom));
  endtask

  // Hold off the sender until every expected result has come
  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Compare each result with the oldest expectation
  task automatic report_mismatch(input string what, input result_t want,
                                 input result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display({"%0t %s: exp byte=%h found=%b acc=%b last=%b free=%0d, ",
                "got byte=%h found=%b acc=%b last=%b free=%0d"},
               $time, what, want.read_byte, want.line_found, want.accepted, want.last,
               want.free_space, got.read_byte, got.line_found, got.accepted, got.last,
               got.free_space);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, result);
      end else begin
        want = expected_results.pop_front();
        if (result.read_byte !== want.read_byte || result.line_found !== want.line_found ||
            result.accepted !== want.accepted || result.last !== want.last ||
            result.free_space !== want.free_space)
          report_mismatch("result mismatch", want, result);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sel;
    int len;
    int line_left;
    directed_rows = '{
      '{'{KIND_READ,   8'h00, 7'd10},  1'b1, single_res(0, 1024)},
      '{'{KIND_WRITE,  8'h41, 7'd0},   1'b1, single_res(1, 1023)},
      '{'{KIND_WRITE,  NEWLINE, 7'd0}, 1'b1, single_res(1, 1022)},
      '{'{KIND_READ,   8'h00, 7'd0},   1'b1, single_res(0, 1022)},
      '{'{KIND_READ,   8'h00, 7'd1},   1'b1, single_res(0, 1022)},
      '{'{KIND_READ,   8'h00, 7'd2},   1'b0, '0},
      '{'{KIND_WRITE,  8'hFF, 7'd127}, 1'b1, single_res(1, 1023)},
      '{'{KIND_WRITE,  8'h00, 7'd0},   1'b1, single_res(1, 1022)},
      '{'{KIND_UNUSED, 8'hFF, 7'd127}, 1'b1, single_res(0, 1022)},
      '{'{KIND_WRITE,  NEWLINE, 7'd0}, 1'b1, single_res(1, 1021)},
      '{'{KIND_READ,   8'h00, 7'd127}, 1'b0, '0},
      '{'{KIND_WRITE,  8'h0B, 7'd0},   1'b1, single_res(1, 1023)},
      '{'{KIND_WRITE,  8'h09, 7'd0},   1'b1, single_res(1, 1022)},
      '{'{KIND_READ,   8'hFF, 7'd64},  1'b1, single_res(0, 1022)},
      '{'{KIND_FLUSH,  8'h00, 7'd0},   1'b1, single_res(0, 1024)},
      '{'{KIND_READ,   8'h00, 7'd64},  1'b1, single_res(0, 1024)},
      '{'{KIND_WRITE,  NEWLINE, 7'd0}, 1'b1, single_res(1, 1023)},
      '{'{KIND_READ,   8'h00, 7'd65},  1'b0, '0},
      '{'{KIND_FLUSH,  8'hFF, 7'd127}, 1'b1, single_res(0, 1024)},
      '{'{KIND_WRITE,  NEWLINE, 7'd0}, 1'b1, single_res(1, 1023)},
      '{'{KIND_WRITE,  NEWLINE, 7'd0}, 1'b1, single_res(1, 1022)},
      '{'{KIND_READ,   8'h00, 7'd1},   1'b0, '0},
      '{'{KIND_READ,   8'h00, 7'd1},   1'b0, '0}
    };

    // Hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
    wait_drain();

    // Lines around the longest window: one short of it, exactly it, one past it
    for (int l = MAX_LINE - 1; l <= MAX_LINE + 1; l++) begin
      push_line(l, 1'b1);
      issue(KIND_READ, 8'h00, 7'(l - 1));
      issue(KIND_READ, 8'h00, 7'(l));
      issue(KIND_READ, 8'h00, 7'd127);
      issue(KIND_FLUSH, 8'h00, 7'd0);
    end

    // Fill to full, overflow, then drain and refill across the wrap point
    line_left = $urandom_range(1, MAX_LINE);
    while (ring_fill < DEPTH) begin
      issue(KIND_WRITE, (line_left == 1) ? NEWLINE : text_byte(), 7'($urandom));
      line_left = (line_left == 1) ? $urandom_range(1, MAX_LINE) : line_left - 1;
    end
    repeat (3) issue(KIND_WRITE, 8'($urandom), 7'($urandom));
    repeat (24) issue(KIND_READ, 8'h00, 7'(MAX_LINE));
    repeat (300) begin
      issue(KIND_WRITE, (line_left == 1) ? NEWLINE : text_byte(), 7'($urandom));
      line_left = (line_left == 1) ? $urandom_range(1, MAX_LINE) : line_left - 1;
    end
    repeat (24) issue(KIND_READ, 8'h00, 7'($urandom_range(1, 127)));
    issue(KIND_FLUSH, 8'h00, 7'd0);
    wait_drain();

    // Random traffic: mostly whole lines and reads, some noise
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12)
                                          : $urandom_range(13, MAX_LINE);
        push_line(len, $urandom_range(0, 9) != 0);
        random_items += len;
      end else if (sel < 80) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) len = 0;
        else if (sel == 1) len = $urandom_range(MAX_LINE + 1, 127);
        else len = $urandom_range(1, MAX_LINE);
        issue(KIND_READ, 8'($urandom), 7'(len));
        random_items++;
      end else if (sel < 85) begin
        issue(KIND_WRITE, 8'($urandom), 7'($urandom));
        random_items++;
      end else if (sel < 88) begin
        issue(KIND_FLUSH, 8'($urandom), 7'($urandom));
        random_items++;
      end else if (sel < 92) begin
        issue(KIND_UNUSED, 8'($urandom), 7'($urandom));
      end else if (sel < 95) begin
        wait_drain();
      end else begin
        sender_idle_on = ~sender_idle_on;
      end
    end

    // Let the last line drain, then allow for the longest read
    wait_drain();
    repeat (2 * MAX_LINE + 10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
